// ----- hdl/fepc_pkg.sv -----
// ----------------------------------------------------------------------------
// fepc_pkg
// Shared types and constants of the flash EEPROM emulation page cache.
// ----------------------------------------------------------------------------
package fepc_pkg;

    localparam int DEF_PAGE_COUNT = 16;
    localparam int PAGE_TAGS      = 16;
    localparam int WORDS_PER_PAGE = 64;
    localparam int WIDX_W         = $clog2(WORDS_PER_PAGE);
    localparam int CNT_W          = WIDX_W + 1;
    localparam int WORD_W         = 32;
    localparam int BYTE_W         = 8;
    localparam int ADDR_W         = 12;
    localparam int TAG_W          = $clog2(PAGE_TAGS);
    localparam int LANE_W         = 2;
    localparam logic [WORD_W-1:0] BYTE_MASK = WORD_W'(8'hFF);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDATA,
        S_MERGE,
        S_FLUSH,
        S_LOAD,
        S_FINISH
    } t_state;

    typedef enum logic {
        REQ_READ  = 1'b0,
        REQ_WRITE = 1'b1
    } t_req;

endpackage

// ----- hdl/fepc_ram.sv -----
// ----------------------------------------------------------------------------
// fepc_ram
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module fepc_ram #(
    parameter int DEPTH  = 64,
    parameter int AW     = 6,
    parameter int DW     = 32
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- hdl/flash_eeprom_page_cache.sv -----
// ----------------------------------------------------------------------------
// flash_eeprom_page_cache
// Byte-addressed EEPROM emulation over word-wide flash with one write-back
// page buffer of 64 words.
// ----------------------------------------------------------------------------
// A read, or a write to the held page, passes through a working state and
// then the output register. A write to another page sweeps the page buffer
// port one word per cycle, first writing the held page back to flash if one
// is held, and then loading the new page.
// Flash pages that were never written back read as zero through one valid
// bit per page, so no clearing pass follows reset. One word is in work at a
// time; a finished result waits in the output register.
module flash_eeprom_page_cache #(
    parameter int PAGE_COUNT = fepc_pkg::DEF_PAGE_COUNT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_req_type,
    input  logic [fepc_pkg::ADDR_W-1:0] i_address,
    input  logic [fepc_pkg::BYTE_W-1:0] i_write_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [fepc_pkg::BYTE_W-1:0] o_read_data,
    output logic                      o_page_hit,
    output logic                      o_page_flushed
);
    import fepc_pkg::*;

    localparam int PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int FADDR_W = PAGE_W + WIDX_W;
    localparam int FDEPTH  = PAGE_COUNT * WORDS_PER_PAGE;

    t_state r_state, n_state;

    logic [PAGE_W-1:0]  w_page_map [PAGE_TAGS];
    logic [PAGE_W-1:0]  w_in_page;
    logic               w_in_hit;
    logic               w_accept;
    logic               w_done_ok;
    logic               w_complete;

    logic               r_req_type;
    logic [ADDR_W-1:0]  r_addr;
    logic [BYTE_W-1:0]  r_data;
    logic [PAGE_W-1:0]  r_page, n_page;
    logic               r_hit, n_hit;
    logic               r_flushed, n_flushed;
    logic [PAGE_W-1:0]  r_held_page, n_held_page;
    logic               r_held_valid, n_held_valid;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [PAGE_COUNT-1:0] r_pg_ok, n_pg_ok;

    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_rd;
    logic               r_out_hit;
    logic               r_out_fl;
    logic [BYTE_W-1:0]  w_res_rd;

    logic [WIDX_W-1:0]  w_widx;
    logic [WIDX_W-1:0]  w_cnt_m1;
    logic [4:0]         w_shift;
    logic [WORD_W-1:0]  w_loaded;
    logic [WORD_W-1:0]  w_word;
    logic [WORD_W-1:0]  w_merged;

    logic               w_buf_we, w_buf_re;
    logic [WIDX_W-1:0]  w_buf_wa, w_buf_ra;
    logic [WORD_W-1:0]  w_buf_wd, w_buf_rd;
    logic               w_fl_we, w_fl_re;
    logic [FADDR_W-1:0] w_fl_wa, w_fl_ra;
    logic [WORD_W-1:0]  w_fl_rd;

    for (genvar g = 0; g < PAGE_TAGS; g++) begin : g_page_map
        assign w_page_map[g] = PAGE_W'(g % PAGE_COUNT);
    end

    assign w_in_page  = w_page_map[i_address[ADDR_W-1:ADDR_W-TAG_W]];
    assign w_in_hit   = r_held_valid && (r_held_page == w_in_page);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_done_ok  = !r_out_valid || !i_out_stall;

    assign w_widx   = r_addr[LANE_W +: WIDX_W];
    assign w_cnt_m1 = WIDX_W'(r_cnt - CNT_W'(1));
    assign w_shift  = {r_addr[LANE_W-1:0], 3'b000};
    assign w_loaded = r_pg_ok[r_page] ? w_fl_rd : '0;
    assign w_merged = (w_word & ~(BYTE_MASK << w_shift))
                    | (WORD_W'(r_data) << w_shift);

    fepc_ram #(
        .DEPTH (WORDS_PER_PAGE),
        .AW    (WIDX_W),
        .DW    (WORD_W)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (w_buf_we),
        .i_wr_addr (w_buf_wa),
        .i_wr_data (w_buf_wd),
        .i_rd_en   (w_buf_re),
        .i_rd_addr (w_buf_ra),
        .o_rd_data (w_buf_rd)
    );

    fepc_ram #(
        .DEPTH (FDEPTH),
        .AW    (FADDR_W),
        .DW    (WORD_W)
    ) u_flash (
        .i_clk     (i_clk),
        .i_wr_en   (w_fl_we),
        .i_wr_addr (w_fl_wa),
        .i_wr_data (w_buf_rd),
        .i_rd_en   (w_fl_re),
        .i_rd_addr (w_fl_ra),
        .o_rd_data (w_fl_rd)
    );

    always_comb begin
        n_state      = r_state;
        n_page       = r_page;
        n_hit        = r_hit;
        n_flushed    = r_flushed;
        n_held_page  = r_held_page;
        n_held_valid = r_held_valid;
        n_cnt        = r_cnt;
        n_pg_ok      = r_pg_ok;
        w_complete   = 1'b0;
        w_res_rd     = '0;
        w_word       = w_buf_rd;
        w_buf_we     = 1'b0;
        w_buf_re     = 1'b0;
        w_buf_wa     = w_cnt_m1;
        w_buf_ra     = i_address[LANE_W +: WIDX_W];
        w_buf_wd     = w_loaded;
        w_fl_we      = 1'b0;
        w_fl_re      = 1'b0;
        w_fl_wa      = {r_held_page, w_cnt_m1};
        w_fl_ra      = {w_in_page, i_address[LANE_W +: WIDX_W]};

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_page    = w_in_page;
                    n_hit     = w_in_hit;
                    n_flushed = 1'b0;
                    n_cnt     = '0;
                    if (i_req_type == REQ_READ) begin
                        w_buf_re = w_in_hit;
                        w_fl_re  = !w_in_hit;
                        n_state  = S_RDATA;
                    end else if (w_in_hit) begin
                        w_buf_re = 1'b1;
                        n_state  = S_MERGE;
                    end else if (r_held_valid) begin
                        n_flushed = 1'b1;
                        n_state   = S_FLUSH;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_RDATA: begin
                w_word   = r_hit ? w_buf_rd : w_loaded;
                w_res_rd = BYTE_W'(w_word >> w_shift);
                if (w_done_ok) begin
                    w_complete = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_MERGE: begin
                if (w_done_ok) begin
                    w_buf_we   = 1'b1;
                    w_buf_wa   = w_widx;
                    w_buf_wd   = w_merged;
                    w_complete = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_FLUSH: begin
                w_buf_re = !r_cnt[CNT_W-1];
                w_buf_ra = r_cnt[WIDX_W-1:0];
                w_fl_we  = (r_cnt != '0);
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt[CNT_W-1]) begin
                    n_pg_ok[r_held_page] = 1'b1;
                    n_cnt   = '0;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                w_word  = w_loaded;
                w_fl_re = !r_cnt[CNT_W-1];
                w_fl_ra = {r_page, r_cnt[WIDX_W-1:0]};
                w_buf_we = (r_cnt != '0);
                w_buf_wd = (w_cnt_m1 == w_widx) ? w_merged : w_loaded;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt[CNT_W-1]) begin
                    n_held_page  = r_page;
                    n_held_valid = 1'b1;
                    n_state      = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_done_ok) begin
                    w_complete = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_held_page  <= '0;
            r_held_valid <= 1'b0;
            r_pg_ok      <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_held_page  <= n_held_page;
            r_held_valid <= n_held_valid;
            r_pg_ok      <= n_pg_ok;
            r_cnt        <= n_cnt;
            if (w_complete) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page    <= n_page;
        r_hit     <= n_hit;
        r_flushed <= n_flushed;
        if (w_accept) begin
            r_req_type <= i_req_type;
            r_addr     <= i_address;
            r_data     <= i_write_data;
        end
        if (w_complete) begin
            r_out_rd  <= (r_req_type == REQ_READ) ? w_res_rd : '0;
            r_out_hit <= r_hit;
            r_out_fl  <= r_flushed;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_out_rd;
    assign o_page_hit     = r_out_hit;
    assign o_page_flushed = r_out_fl;
endmodule

// ----- sim/flash_eeprom_page_cache_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_eeprom_page_cache_chk
// Watches both channels of the page cache, keeps its own copy of the page
// buffer and the flash array, and checks every result word against it.
// ----------------------------------------------------------------------------
module flash_eeprom_page_cache_chk #(
    parameter int PAGE_COUNT = fepc_pkg::DEF_PAGE_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_req_type,
    input  logic [fepc_pkg::ADDR_W-1:0]   i_address,
    input  logic [fepc_pkg::BYTE_W-1:0]   i_write_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [fepc_pkg::BYTE_W-1:0]   i_read_data,
    input  logic                          i_page_hit,
    input  logic                          i_page_flushed,
    output int                            o_fail_count,
    output int                            o_pending
);
    import fepc_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              page_hit;
        logic              page_flushed;
    } t_reply;

    t_reply            awaited_replies[$];
    logic [WORD_W-1:0] flash_mem[PAGE_COUNT*WORDS_PER_PAGE];
    logic [WORD_W-1:0] page_buf[WORDS_PER_PAGE];
    int unsigned       held_tag;
    bit                held_ok;

    function automatic t_reply predict_cache_access(t_req req, logic [ADDR_W-1:0] addr,
                                                    logic [BYTE_W-1:0] data);
        int unsigned       tag;
        int unsigned       widx;
        int unsigned       lane;
        logic [WORD_W-1:0] word;
        t_reply            r;
        bit                hit;
        tag  = addr[ADDR_W-1:8] % PAGE_COUNT;
        widx = addr[7:2];
        lane = addr[1:0];
        hit  = held_ok && (held_tag == tag);
        r = '0;
        r.page_hit = hit;
        if (req == REQ_WRITE) begin
            if (!hit) begin
                if (held_ok) begin
                    for (int i = 0; i < WORDS_PER_PAGE; i++) begin
                        flash_mem[held_tag*WORDS_PER_PAGE + i] = page_buf[i];
                    end
                    r.page_flushed = 1'b1;
                end
                for (int i = 0; i < WORDS_PER_PAGE; i++) begin
                    page_buf[i] = flash_mem[tag*WORDS_PER_PAGE + i];
                end
                held_tag = tag;
                held_ok  = 1'b1;
            end
            word = page_buf[widx];
            word[lane*BYTE_W +: BYTE_W] = data;
            page_buf[widx] = word;
        end else begin
            word = hit ? page_buf[widx] : flash_mem[tag*WORDS_PER_PAGE + widx];
            r.read_data = word[lane*BYTE_W +: BYTE_W];
        end
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < PAGE_COUNT*WORDS_PER_PAGE; i++) begin
                flash_mem[i] = '0;
            end
            for (int i = 0; i < WORDS_PER_PAGE; i++) begin
                page_buf[i] = '0;
            end
            held_tag = 0;
            held_ok  = 1'b0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_replies.size() == 0) begin
                    $error("result word with no access waiting: read_data %0h hit %0b flushed %0b",
                           i_read_data, i_page_hit, i_page_flushed);
                    o_fail_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    o_pending--;
                    if (i_read_data !== want.read_data) begin
                        $error("read_data: expected %0h, got %0h", want.read_data, i_read_data);
                        o_fail_count++;
                    end
                    if (i_page_hit !== want.page_hit) begin
                        $error("page_hit: expected %0b, got %0b", want.page_hit, i_page_hit);
                        o_fail_count++;
                    end
                    if (i_page_flushed !== want.page_flushed) begin
                        $error("page_flushed: expected %0b, got %0b",
                               want.page_flushed, i_page_flushed);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_replies.push_back(predict_cache_access(t_req'(i_req_type), i_address,
                                                               i_write_data));
                o_pending++;
            end
        end
    end

endmodule

// ----- sim/flash_eeprom_page_cache_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_eeprom_page_cache_tb
// Drives byte reads and writes into the page cache, first a directed set
// that walks page hits, misses and write-backs, then random accesses that
// mostly stay within a few pages, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module flash_eeprom_page_cache_tb;
    import fepc_pkg::*;

    localparam int RANDOM_ACCESSES = 2000;
    localparam int LONG_HOLD_AT    = 300;
    localparam int LONG_HOLD_LEN   = 400;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 150;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              req_type = REQ_READ;
    logic [ADDR_W-1:0] address = '0;
    logic [BYTE_W-1:0] write_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b1;
    logic [BYTE_W-1:0] read_data;
    logic              page_hit;
    logic              page_flushed;
    int                fail_count;
    int                pending;
    int                accesses_sent = 0;
    int                words_taken = 0;
    bit                long_hold = 1'b0;

    flash_eeprom_page_cache dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_address     (address),
        .i_write_data  (write_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_read_data   (read_data),
        .o_page_hit    (page_hit),
        .o_page_flushed(page_flushed)
    );

    flash_eeprom_page_cache_chk chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_address     (address),
        .i_write_data  (write_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_read_data   (read_data),
        .i_page_hit    (page_hit),
        .i_page_flushed(page_flushed),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #5 clk = ~clk;

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic issue_access(t_req req, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
        int gap;
        gap = (long_hold || ((accesses_sent / 150) % 3 == 2)) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        address    <= addr;
        write_data <= data;
        do @(posedge clk); while (in_stall);
        accesses_sent++;
    endtask

    // The receiver takes one word per loop and holds off once for a long stretch.
    initial begin
        int hold;
        while (!rst_n) @(posedge clk);
        forever begin
            if (words_taken == LONG_HOLD_AT && !long_hold) begin
                long_hold = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_LEN) @(posedge clk);
                long_hold = 1'b0;
            end
            hold = ((words_taken / 150) % 3 == 1) ? 0 : $urandom_range(0, 12);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            words_taken++;
        end
    end

    initial begin
        logic [3:0]        hot_pages[3];
        logic [ADDR_W-1:0] addr;
        int                waited;
        while (!rst_n) @(posedge clk);

        issue_access(REQ_READ,  12'h000, 8'h00);
        issue_access(REQ_READ,  12'hFFF, 8'hFF);
        issue_access(REQ_WRITE, 12'h000, 8'hA5);
        issue_access(REQ_READ,  12'h000, 8'h00);
        issue_access(REQ_WRITE, 12'h001, 8'hFF);
        issue_access(REQ_WRITE, 12'h002, 8'h00);
        issue_access(REQ_WRITE, 12'h003, 8'h5A);
        issue_access(REQ_READ,  12'h003, 8'hFF);
        issue_access(REQ_WRITE, 12'h0FF, 8'hFF);
        issue_access(REQ_WRITE, 12'hFFC, 8'h3C);
        issue_access(REQ_READ,  12'h000, 8'h00);
        issue_access(REQ_READ,  12'h0FF, 8'h00);
        issue_access(REQ_READ,  12'hFFC, 8'h00);
        issue_access(REQ_WRITE, 12'hF00, 8'h81);
        issue_access(REQ_WRITE, 12'h7AB, 8'hC3);
        issue_access(REQ_READ,  12'hFFC, 8'h00);
        issue_access(REQ_WRITE, 12'h0FE, 8'h7E);
        issue_access(REQ_READ,  12'h000, 8'h00);
        issue_access(REQ_READ,  12'h7AB, 8'h00);
        issue_access(REQ_READ,  12'h555, 8'hAA);

        // Most accesses stay within a few pages so that hits dominate.
        for (int i = 0; i < 3; i++) begin
            hot_pages[i] = 4'($urandom_range(0, 15));
        end
        for (int n = 0; n < RANDOM_ACCESSES; n++) begin
            if (n % 100 == 99) begin
                hot_pages[$urandom_range(0, 2)] = 4'($urandom_range(0, 15));
            end
            if ($urandom_range(0, 9) == 0) begin
                addr = ADDR_W'($urandom);
            end else if ($urandom_range(0, 3) == 0) begin
                addr = {hot_pages[$urandom_range(1, 2)], 8'($urandom)};
            end else begin
                addr = {hot_pages[0], 8'($urandom)};
            end
            issue_access(($urandom_range(0, 99) < 45) ? REQ_WRITE : REQ_READ, addr,
                         8'($urandom));
        end
        in_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
